[design/texture_coordinate_tiler_unit_macros.svh]
// assertion macros for the texture coordinate tiler
`ifndef TEXTURE_COORDINATE_TILER_UNIT_MACROS_SVH
`define TEXTURE_COORDINATE_TILER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TCT_ASSERT_ALWAYS(lbl, ck, rn, expr) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (expr)) else $error("tct check failed");
`define TCT_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("tct check failed");
`else
`define TCT_ASSERT_ALWAYS(lbl, ck, rn, expr)
`define TCT_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

[design/tct_pkg.sv]
// shared types and constants for the texture coordinate tiler
package tct_pkg;
  localparam int MaxTextureDim = 4096;
  localparam int MaxScreenDim  = 4096;
  localparam int FracBits      = 17;
  localparam int DimW          = 13;
  localparam int DivW          = DimW + 1;
  localparam int QuotW         = 30;
  localparam int BitsPerStage  = 5;
  localparam int RemStages     = QuotW / BitsPerStage;

  typedef enum logic [1:0] {
    MODE_CLAMP  = 2'd0,
    MODE_REPEAT = 2'd1,
    MODE_MIRROR = 2'd2,
    MODE_SPARE  = 2'd3
  } tile_mode_t;

  typedef enum logic [2:0] {
    REG_XX = 3'd0, REG_XY = 3'd1, REG_XT = 3'd2, REG_YX = 3'd3,
    REG_YY = 3'd4, REG_YT = 3'd5, REG_MODE = 3'd6, REG_EXTENT = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [DimW-1:0]  rem;
    logic [QuotW-1:0] dvd;
    logic             neg;
    logic             fnz;
    logic [DimW-1:0]  clampv;
  } rem_t;
endpackage

[design/tct_rem_stage.sv]
// one stage of the pipelined remainder unit, several dividend bits per stage
module tct_rem_stage (
  input  logic                  clk,
  input  logic                  en,
  input  logic [tct_pkg::DivW-1:0] div,
  input  tct_pkg::rem_t         d_in,
  output tct_pkg::rem_t         d_out_r
);
  import tct_pkg::*;

  rem_t d_nxt;

  always_comb begin
    logic [DivW-1:0] t;
    d_nxt = d_in;
    for (int i = 0; i < BitsPerStage; i++) begin
      t = {d_nxt.rem, d_nxt.dvd[QuotW-1]};
      d_nxt.dvd = {d_nxt.dvd[QuotW-2:0], 1'b0};
      if (t >= div) begin
        t = t - div;
      end
      d_nxt.rem = t[DimW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out_r <= d_nxt;
    end
  end
endmodule

[design/texture_coordinate_tiler_unit.sv]
// texture coordinate tiler: affine map of pixel centers and tiling to texel addresses
// pipeline from input transaction to result: 4 arithmetic stages,
// 6 remainder stages of 5 bits each, 1 output register
// throughput: one transaction per cycle while the output is not stalled, set by the fully pipelined remainder unit
// per-stage ready lets items close bubbles while the output is stalled
// reset: synchronous active-low rst_n clears valids and loads identity matrix,
// clamp mode and a 1x1 texture
`include "texture_coordinate_tiler_unit_macros.svh"
module texture_coordinate_tiler_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // pixel_x[11:0], pixel_y[23:12]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // texel_col[11:0], texel_row[23:12]
  output logic        out_tlast
);
  import tct_pkg::*;

  logic signed [31:0] xx_r, xy_r, xt_r, yx_r, yy_r, yt_r;
  tile_mode_t         mode_r;
  logic [28:0]        ext_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xx_r <= 32'sd65536; xy_r <= '0; xt_r <= '0;
      yx_r <= '0; yy_r <= 32'sd65536; yt_r <= '0;
      mode_r <= MODE_CLAMP;
      ext_r <= 29'd65537;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_XX:     xx_r <= cfg_wdata;
        REG_XY:     xy_r <= cfg_wdata;
        REG_XT:     xt_r <= cfg_wdata;
        REG_YX:     yx_r <= cfg_wdata;
        REG_YY:     yy_r <= cfg_wdata;
        REG_YT:     yt_r <= cfg_wdata;
        REG_MODE:   mode_r <= tile_mode_t'(cfg_wdata[1:0]);
        REG_EXTENT: ext_r <= cfg_wdata[28:0];
        default: ;
      endcase
    end
  end

  function automatic logic [DimW-1:0] fix_dim(input logic [DimW-1:0] d);
    if (d == '0) return DimW'(1);
    if ({1'b0, d} > (DimW+1)'(MaxTextureDim)) return DimW'(MaxTextureDim);
    return d;
  endfunction

  logic [DimW-1:0] w_dim, h_dim;
  logic [DivW-1:0] div_u, div_v;
  logic            mirror;
  assign w_dim  = fix_dim(ext_r[12:0]);
  assign h_dim  = fix_dim(ext_r[28:16]);
  assign mirror = (mode_r == MODE_MIRROR);
  assign div_u  = mirror ? {w_dim, 1'b0} : {1'b0, w_dim};
  assign div_v  = mirror ? {h_dim, 1'b0} : {1'b0, h_dim};

  // stage enables, rippled back from the output
  logic v0_r, v1_r, v2_r, v3_r, out_vld_r;
  logic [RemStages-1:0] rv_r;
  logic en0, en1, en2, en3, en_out;
  logic [RemStages-1:0] en_rem;

  assign en_out = ~out_vld_r | out_tready;
  always_comb begin
    en_rem[RemStages-1] = ~rv_r[RemStages-1] | en_out;
    for (int k = RemStages - 2; k >= 0; k--) begin
      en_rem[k] = ~rv_r[k] | en_rem[k+1];
    end
  end
  assign en3 = ~v3_r | en_rem[0];
  assign en2 = ~v2_r | en3;
  assign en1 = ~v1_r | en2;
  assign en0 = ~v0_r | en1;
  assign in_tready = en0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0; v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0;
      rv_r <= '0; out_vld_r <= 1'b0;
    end else begin
      if (en0) v0_r <= in_tvalid;
      if (en1) v1_r <= v0_r;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en_rem[0]) rv_r[0] <= v3_r;
      for (int k = 1; k < RemStages; k++) begin
        if (en_rem[k]) rv_r[k] <= rv_r[k-1];
      end
      if (en_out) out_vld_r <= rv_r[RemStages-1];
    end
  end

  // stage 0: saturate and form doubled pixel centers
  logic [12:0] x2_r, y2_r;
  logic [11:0] sx, sy;
  logic        l0_r, l1_r, l2_r, l3_r, out_last_r;
  logic [RemStages-1:0] rl_r;

  assign sx = ({1'b0, in_tdata[11:0]} > 13'(MaxScreenDim - 1)) ?
              12'(MaxScreenDim - 1) : in_tdata[11:0];
  assign sy = ({1'b0, in_tdata[23:12]} > 13'(MaxScreenDim - 1)) ?
              12'(MaxScreenDim - 1) : in_tdata[23:12];

  always_ff @(posedge clk) begin
    if (en0) begin
      x2_r <= {sx, 1'b1};
      y2_r <= {sy, 1'b1};
      l0_r <= in_tlast;
    end
  end

  // stage 1: products
  logic signed [45:0] pxx_r, pxy_r, pyx_r, pyy_r;
  always_ff @(posedge clk) begin
    if (en1) begin
      pxx_r <= 46'(xx_r * $signed({1'b0, x2_r}));
      pxy_r <= 46'(xy_r * $signed({1'b0, y2_r}));
      pyx_r <= 46'(yx_r * $signed({1'b0, x2_r}));
      pyy_r <= 46'(yy_r * $signed({1'b0, y2_r}));
      l1_r  <= l0_r;
    end
  end

  // stage 2: sums with 17 fraction bits
  logic signed [46:0] u_r, v_r;
  always_ff @(posedge clk) begin
    if (en2) begin
      u_r  <= 47'(pxx_r) + 47'(pxy_r) + (47'(xt_r) <<< 1);
      v_r  <= 47'(pyx_r) + 47'(pyy_r) + (47'(yt_r) <<< 1);
      l2_r <= l1_r;
    end
  end

  // stage 3: integer part, magnitude and clamp candidate
  function automatic rem_t prep(input logic signed [46:0] p, input logic [DimW-1:0] dim);
    rem_t r;
    logic signed [QuotW-1:0] q;
    q = p[46:FracBits];
    r.rem = '0;
    r.neg = q[QuotW-1];
    r.fnz = (p[FracBits-1:0] != '0);
    r.dvd = r.neg ? QuotW'(-q) : QuotW'(q);
    if (r.neg) begin
      r.clampv = '0;
    end else if (q > $signed({{(QuotW-DimW){1'b0}}, dim - DimW'(1)})) begin
      r.clampv = dim - DimW'(1);
    end else begin
      r.clampv = q[DimW-1:0];
    end
    return r;
  endfunction

  rem_t pu_r, pv_r;
  always_ff @(posedge clk) begin
    if (en3) begin
      pu_r <= prep(u_r, w_dim);
      pv_r <= prep(v_r, h_dim);
      l3_r <= l2_r;
    end
  end

  // stages 4..9: remainder of the integer part
  rem_t ru [RemStages+1];
  rem_t rv [RemStages+1];
  assign ru[0] = pu_r;
  assign rv[0] = pv_r;

  for (genvar k = 0; k < RemStages; k++) begin : g_rem
    tct_rem_stage u_stage (.clk(clk), .en(en_rem[k]), .div(div_u), .d_in(ru[k]),
                           .d_out_r(ru[k+1]));
    tct_rem_stage v_stage (.clk(clk), .en(en_rem[k]), .div(div_v), .d_in(rv[k]),
                           .d_out_r(rv[k+1]));
  end

  always_ff @(posedge clk) begin
    if (en_rem[0]) rl_r[0] <= l3_r;
    for (int k = 1; k < RemStages; k++) begin
      if (en_rem[k]) rl_r[k] <= rl_r[k-1];
    end
  end

  // stage 10: apply the tile rule
  function automatic logic [DimW-1:0] tile_fin(input rem_t r, input logic [DivW-1:0] d,
                                               input logic [DimW-1:0] dim,
                                               input tile_mode_t md);
    logic [DivW-1:0] m;
    logic [DivW-1:0] dm;
    dm = {1'b0, dim};
    m  = {1'b0, r.rem};
    if (r.neg && (r.rem != '0)) m = d - m;
    unique case (md)
      MODE_REPEAT: return m[DimW-1:0];
      MODE_MIRROR: begin
        if ((m > dm) || ((m == dm) && r.fnz)) m = d - m - DivW'(r.fnz);
        if (m > dm - DivW'(1)) m = dm - DivW'(1);
        return m[DimW-1:0];
      end
      default: return r.clampv;
    endcase
  endfunction

  logic [DimW-1:0] col_r, row_r;
  always_ff @(posedge clk) begin
    if (en_out) begin
      col_r      <= tile_fin(ru[RemStages], div_u, w_dim, mode_r);
      row_r      <= tile_fin(rv[RemStages], div_v, h_dim, mode_r);
      out_last_r <= rl_r[RemStages-1];
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {row_r[11:0], col_r[11:0]};
  assign out_tlast  = out_last_r;

  `TCT_ASSERT_ALWAYS(a_col_in_range, clk, rst_n, !out_vld_r || (col_r < w_dim))
  `TCT_ASSERT_ALWAYS(a_row_in_range, clk, rst_n, !out_vld_r || (row_r < h_dim))
  `TCT_ASSERT_ALWAYS(a_rem_below_div, clk, rst_n, !rv_r[RemStages-1] || ({1'b0, ru[RemStages].rem} < div_u))
  `TCT_ASSERT_NEXT(a_stall_holds, clk, rst_n, rv_r[RemStages-1] && out_vld_r && !out_tready, rv_r[RemStages-1] && out_vld_r)
endmodule

[dv/texture_coordinate_tiler_unit_test.sv]
// self-checking stream testbench for the texture coordinate tiler unit
module texture_coordinate_tiler_unit_test;
  import tct_pkg::*;

  typedef struct {
    logic signed [31:0] xx, xy, xt, yx, yy, yt;
    tile_mode_t         mode;
    logic [28:0]        extent;
  } tiler_regs_t;

  typedef struct {
    logic [11:0] col;
    logic [11:0] row;
    logic        last;
  } texel_t;

  typedef struct {
    int   preset;
    int   px, py, last;
    bit   typed;
    int   col, row;
  } pixel_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // pixel_x[11:0], pixel_y[23:12]
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // texel_col[11:0], texel_row[23:12]
  logic        out_tlast;

  tiler_regs_t active_regs;
  texel_t      texel_queue[$];
  int          error_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          active_preset = 0;

  pixel_row_t  directed[23] = '{
    // reset state: 1x1 texture, everything lands on texel 0
    '{0, 0, 0, 0, 1, 0, 0},
    '{0, 4095, 4095, 1, 1, 0, 0},
    '{0, 4095, 0, 0, 1, 0, 0},
    '{0, 0, 4095, 1, 1, 0, 0},
    // identity, clamp, full size texture
    '{1, 0, 0, 0, 1, 0, 0},
    '{1, 4095, 4095, 1, 1, 4095, 4095},
    '{1, 4095, 0, 0, 1, 4095, 0},
    // repeat with scale and negative offset
    '{2, 0, 0, 0, 0, 0, 0},
    '{2, 4095, 4095, 1, 0, 0, 0},
    '{2, 37, 5, 0, 0, 0, 0},
    '{2, 1234, 2047, 1, 0, 0, 0},
    // mirror with flipped axis
    '{3, 0, 0, 0, 0, 0, 0},
    '{3, 6, 2, 1, 0, 0, 0},
    '{3, 13, 11, 0, 0, 0, 0},
    '{3, 4095, 4095, 1, 0, 0, 0},
    // spare mode acts as clamp, extreme shear
    '{4, 0, 0, 0, 0, 0, 0},
    '{4, 4095, 4095, 1, 0, 0, 0},
    '{4, 100, 3000, 0, 0, 0, 0},
    // zero width and height
    '{5, 777, 3333, 1, 1, 0, 0},
    '{5, 4095, 0, 0, 1, 0, 0},
    // oversized extent saturates, extreme coefficients
    '{6, 0, 0, 0, 0, 0, 0},
    '{6, 4095, 4095, 1, 0, 0, 0},
    '{6, 2048, 1024, 0, 0, 0, 0}
  };

  texture_coordinate_tiler_unit DUT (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint fix_dim(logic [12:0] d);
    if (d == 0) return 1;
    if (d > MaxTextureDim) return MaxTextureDim;
    return longint'(d);
  endfunction

  function automatic logic [11:0] tile_index(longint p, longint dim, tile_mode_t mode);
    longint one;
    longint span;
    longint m;
    longint idx;
    one = 64'sd1 <<< FracBits;
    span = dim * one;
    case (mode)
      MODE_REPEAT: begin
        m = p % span;
        if (m < 0) m = m + span;
        idx = m / one;
      end
      MODE_MIRROR: begin
        m = p % (2 * span);
        if (m < 0) m = m + 2 * span;
        if (m > span) m = 2 * span - m;
        idx = m / one;
        if (idx > dim - 1) idx = dim - 1;
      end
      default: begin
        idx = (p < 0) ? 0 : p / one;
        if (idx > dim - 1) idx = dim - 1;
      end
    endcase
    return idx[11:0];
  endfunction

  function automatic texel_t map_pixel(logic [11:0] px, logic [11:0] py, logic last);
    texel_t t;
    longint x2;
    longint y2;
    longint u;
    longint v;
    x2 = 2 * longint'(px) + 1;
    y2 = 2 * longint'(py) + 1;
    u = longint'(active_regs.xx) * x2 + longint'(active_regs.xy) * y2
        + 2 * longint'(active_regs.xt);
    v = longint'(active_regs.yx) * x2 + longint'(active_regs.yy) * y2
        + 2 * longint'(active_regs.yt);
    t.col = tile_index(u, fix_dim(active_regs.extent[12:0]), active_regs.mode);
    t.row = tile_index(v, fix_dim(active_regs.extent[28:16]), active_regs.mode);
    t.last = last;
    return t;
  endfunction

  function automatic logic [28:0] pack_extent(int w, int h);
    logic [28:0] e;
    e = '0;
    e[12:0] = w[12:0];
    e[28:16] = h[12:0];
    return e;
  endfunction

  function automatic logic signed [31:0] pick_coef();
    case ($urandom_range(0, 6))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return $urandom;
      3: return 0;
      default: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
    endcase
  endfunction

  function automatic int pick_dim();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 4096;
      2: return $urandom_range(0, 8191);
      default: return $urandom_range(1, 64);
    endcase
  endfunction

  task automatic cfg_write(reg_idx_t idx, logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic program_tiler(tiler_regs_t r);
    cfg_write(REG_XX, r.xx);
    cfg_write(REG_XY, r.xy);
    cfg_write(REG_XT, r.xt);
    cfg_write(REG_YX, r.yx);
    cfg_write(REG_YY, r.yy);
    cfg_write(REG_YT, r.yt);
    cfg_write(REG_MODE, {30'd0, r.mode});
    cfg_write(REG_EXTENT, {3'd0, r.extent});
    cfg_we <= 1'b0;
    active_regs = r;
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (texel_queue.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic send_pixel(int px, int py, int last, bit typed, int col, int row);
    texel_t t;
    int gap;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      gap = $urandom_range(1, 4);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {py[11:0], px[11:0]};
    in_tlast <= last[0];
    do @(posedge clk); while (!in_tready);
    if (typed) begin
      t.col = col[11:0];
      t.row = row[11:0];
      t.last = last[0];
    end else begin
      t = map_pixel(px[11:0], py[11:0], last[0]);
    end
    texel_queue.push_back(t);
  endtask

  task automatic apply_preset(int k);
    tiler_regs_t r;
    r = '{32'sd65536, 0, 0, 0, 32'sd65536, 0, MODE_CLAMP, pack_extent(1, 1)};
    case (k)
      1: r.extent = pack_extent(4096, 4096);
      2: begin
        r.mode = MODE_REPEAT;
        r.xx = 32'sd163840;
        r.yy = 32'sd98304;
        r.xt = -32'sd6569984;
        r.yt = -32'sd32768;
        r.extent = pack_extent(37, 5);
      end
      3: begin
        r.mode = MODE_MIRROR;
        r.xx = -32'sd65536;
        r.yy = 32'sd32768;
        r.xt = 32'sd655360;
        r.extent = pack_extent(7, 3);
      end
      4: begin
        r.mode = MODE_SPARE;
        r.xy = 32'sh7fff_ffff;
        r.yx = 32'sh8000_0000;
        r.extent = pack_extent(300, 4000);
      end
      5: begin
        r.mode = MODE_REPEAT;
        r.extent = pack_extent(0, 0);
      end
      6: begin
        r = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
              32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
              MODE_MIRROR, pack_extent(8191, 8191)};
      end
      default: ;
    endcase
    program_tiler(r);
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    texel_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (texel_queue.size() == 0) begin
        $display("%0t unexpected transaction: expected none, got col %0d row %0d last %0b",
                 $time, out_tdata[11:0], out_tdata[23:12], out_tlast);
        error_count++;
      end else begin
        want = texel_queue.pop_front();
        if (out_tdata[11:0] !== want.col || out_tdata[23:12] !== want.row ||
            out_tlast !== want.last) begin
          $display("%0t mismatch: expected col %0d row %0d last %0b, got col %0d row %0d last %0b",
                   $time, want.col, want.row, want.last,
                   out_tdata[11:0], out_tdata[23:12], out_tlast);
          error_count++;
        end
      end
    end
  end

  initial begin
    tiler_regs_t r;
    int stall_plan[4][2];
    stall_plan = '{'{0, 0}, '{70, 0}, '{0, 70}, '{36, 36}};
    active_regs = '{32'sd65536, 0, 0, 0, 32'sd65536, 0, MODE_CLAMP, pack_extent(1, 1)};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].preset != active_preset) begin
        wait_idle();
        apply_preset(directed[i].preset);
        active_preset = directed[i].preset;
      end
      send_pixel(directed[i].px, directed[i].py, directed[i].last,
                 directed[i].typed, directed[i].col, directed[i].row);
    end

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = stall_plan[p][0];
      recv_stall_pct = stall_plan[p][1];
      for (int blk = 0; blk < 8; blk++) begin
        wait_idle();
        r.xx = pick_coef();
        r.xy = pick_coef();
        r.xt = pick_coef();
        r.yx = pick_coef();
        r.yy = pick_coef();
        r.yt = pick_coef();
        r.mode = tile_mode_t'($urandom_range(0, 3));
        r.extent = pack_extent(pick_dim(), pick_dim());
        program_tiler(r);
        for (int i = 0; i < 29; i++) begin
          send_pixel($urandom_range(0, 4095), $urandom_range(0, 4095),
                     $urandom_range(0, 1), 1'b0, 0, 0);
        end
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

[sim.f]
+incdir+design
design/tct_pkg.sv
design/tct_rem_stage.sv
design/texture_coordinate_tiler_unit.sv
dv/texture_coordinate_tiler_unit_test.sv
